[rtl/tdpt_pkg.sv]
`default_nettype none

package tdpt_pkg;

	// verdict codes carried on the result stream
	localparam int unsigned VERDICT_W   = 2;
	localparam int unsigned OUT_TDATA_W = 8;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_NONE      = 2'd0,
		VERDICT_PRIME     = 2'd1,
		VERDICT_COMPOSITE = 2'd2
	} verdict_t;

	// status returned by the remainder unit
	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

`default_nettype wire

[rtl/tdpt_rem.sv]
`default_nettype none

// restoring remainder unit, one dividend bit per cycle
module tdpt_rem
	import tdpt_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] dividend,
	input  wire logic [DATA_WIDTH-1:0] divisor,
	output rem_stat_t                  stat
);

	localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DATA_WIDTH:0]   rem_q;
	logic [DATA_WIDTH-1:0] dvd_q;
	logic [DATA_WIDTH-1:0] dsr_q;

	logic [DATA_WIDTH:0] trial;
	logic [DATA_WIDTH:0] dsr_ext;
	logic                fits;

	assign trial   = {rem_q[DATA_WIDTH-1:0], dvd_q[DATA_WIDTH-1]};
	assign dsr_ext = {1'b0, dsr_q};
	assign fits    = (trial >= dsr_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(DATA_WIDTH - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - dsr_ext) : trial;
			dvd_q <= {dvd_q[DATA_WIDTH-2:0], 1'b0};
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule

`default_nettype wire

[rtl/trial_division_prime_test.sv]
`default_nettype none

// channel   direction  payload (lowest bit up)
// s_*       in         candidate, DATA_WIDTH bits signed, zero padded to bytes
// m_*       out        verdict, 2 bits (none / prime / composite), zero padded to 8
//
// one candidate at a time; s_tready is high only while the sequencer is idle
// trivial cases (negative, below four, even) go from the idle state through ST_DONE to the output register
// odd candidates run divisors d = 3, 5, 7 ... while d*d <= n,
// each trial in the shared bit-serial remainder unit
// a finished verdict waits in the output register, the next candidate is taken meanwhile
// arst_n clears the sequencer and the output valid; no state survives an item
module trial_division_prime_test
	import tdpt_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,  // candidate
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [OUT_TDATA_W-1:0]                   m_tdata   // verdict
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WAIT,
		ST_DONE
	} state_t;

	localparam int unsigned SQ_W = DATA_WIDTH + 2;

	state_t                state_q;
	verdict_t              verdict_q;
	logic                  m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                  rem_start_q;

	// working registers of the trial loop
	logic [DATA_WIDTH-1:0] n_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [SQ_W-1:0]       sq_q;

	logic [DATA_WIDTH-1:0] cand;
	logic                  s_xfer;
	logic                  out_free;
	logic                  sq_past;
	logic [SQ_W-1:0]       sq_next;
	rem_stat_t             rem_stat;

	assign cand     = s_tdata[DATA_WIDTH-1:0];
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign sq_past  = (sq_q > {2'b00, n_q});
	// (d+2)^2 = d^2 + 4d + 4
	assign sq_next  = sq_q + {d_q, 2'b00} + SQ_W'(4);

	tdpt_rem #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start_q),
		.dividend(n_q),
		.divisor (d_q),
		.stat    (rem_stat)
	);

	// sequencer with the registered stream outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			verdict_q   <= VERDICT_NONE;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			rem_start_q <= 1'b0;
		end else begin
			// a trial starts in the cycle after the root check passes
			rem_start_q <= (state_q == ST_CHECK) && !sq_past;
			// in ST_DONE the output register is either stalled or reloaded below
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						if (cand[DATA_WIDTH-1]) begin
							verdict_q <= VERDICT_NONE;
							state_q   <= ST_DONE;
						end else if (cand < DATA_WIDTH'(2)) begin
							verdict_q <= VERDICT_NONE;
							state_q   <= ST_DONE;
						end else if (cand < DATA_WIDTH'(4)) begin
							verdict_q <= VERDICT_PRIME;
							state_q   <= ST_DONE;
						end else if (!cand[0]) begin
							verdict_q <= VERDICT_COMPOSITE;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					// no divisor up to the square root: prime
					if (sq_past) begin
						verdict_q <= VERDICT_PRIME;
						state_q   <= ST_DONE;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (rem_stat.done) begin
						if (rem_stat.zero) begin
							verdict_q <= VERDICT_COMPOSITE;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_DONE: begin
					// hold the verdict until the output register is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{(OUT_TDATA_W - VERDICT_W){1'b0}}, verdict_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// candidate and divisor registers
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			n_q  <= cand;
			d_q  <= DATA_WIDTH'(3);
			sq_q <= SQ_W'(9);
		end else if (state_q == ST_WAIT && rem_stat.done && !rem_stat.zero) begin
			d_q  <= d_q + DATA_WIDTH'(2);
			sq_q <= sq_next;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

[rtl/tdpt_checker.sv]
`default_nettype none

module tdpt_checker
	import tdpt_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [OUT_TDATA_W-1:0]          m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one candidate at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// negative candidate with a free output is reported with the verdict none
	a_negative: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid && s_tdata[DATA_WIDTH-1]
		|=> ##1 m_tvalid && (m_tdata[VERDICT_W-1:0] == VERDICT_NONE))
		else $error("negative candidate not flagged");

	// two is prime without any trial
	a_two: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid && (s_tdata[DATA_WIDTH-1:0] == DATA_WIDTH'(2))
		|=> ##1 m_tvalid && (m_tdata[VERDICT_W-1:0] == VERDICT_PRIME))
		else $error("two not reported prime");

endmodule

bind trial_division_prime_test tdpt_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_tdpt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

[dv/prime_verdict_checker.sv]
`default_nettype none

module prime_verdict_checker
	import tdpt_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,  // candidate
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [OUT_TDATA_W-1:0]          m_tdata,  // verdict, zero pad
	output int                                   mismatches,
	output int                                   outstanding,
	output int                                   verdicts_checked,
	output int                                   primes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	verdict_t awaited_verdicts [$];
	int err_count = 0;
	int checked   = 0;
	int primes    = 0;

	initial begin
		mismatches       = 0;
		outstanding      = 0;
		verdicts_checked = 0;
		primes_seen      = 0;
	end

	// sign bit set means below two; below four and even are decided directly, otherwise odd trial divisors up to the root
	function automatic verdict_t predict_verdict(input logic [DATA_WIDTH-1:0] raw);
		longint unsigned n;
		longint unsigned d;
		if (raw[DATA_WIDTH-1])
			return VERDICT_NONE;
		n = raw;
		if (n < 2)
			return VERDICT_NONE;
		if (n < 4)
			return VERDICT_PRIME;
		if (n[0] == 1'b0)
			return VERDICT_COMPOSITE;
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0)
				return VERDICT_COMPOSITE;
		end
		return VERDICT_PRIME;
	endfunction

	task automatic flag_mismatch(input string what, input logic [OUT_TDATA_W-1:0] want,
			input logic [OUT_TDATA_W-1:0] got);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// result side first: a verdict never leaves in the cycle its candidate arrives
			if (m_tvalid && m_tready) begin
				if (awaited_verdicts.size() == 0) begin
					flag_mismatch("verdict with no candidate pending", '0, m_tdata);
				end else begin
					verdict_t want;
					want = awaited_verdicts.pop_front();
					checked++;
					if (m_tdata[VERDICT_W-1:0] !== want)
						flag_mismatch("verdict", OUT_TDATA_W'(want), m_tdata);
					if (m_tdata[OUT_TDATA_W-1:VERDICT_W] !== '0)
						flag_mismatch("verdict padding", OUT_TDATA_W'(want), m_tdata);
					if (want == VERDICT_PRIME)
						primes++;
				end
			end
			if (s_tvalid && s_tready)
				awaited_verdicts.push_back(predict_verdict(s_tdata[DATA_WIDTH-1:0]));
		end
		mismatches       <= err_count;
		outstanding      <= awaited_verdicts.size();
		verdicts_checked <= checked;
		primes_seen      <= primes;
	end

endmodule

`default_nettype wire

[dv/tb_trial_division_prime_test.sv]
`default_nettype none

module tb_trial_division_prime_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DW       = 32;
	localparam int unsigned S_DATA_W = ((DW + 7) / 8) * 8;
	localparam int unsigned RANDOM_ITEMS = 76;
	// 2^31-1 alone needs ~23k trials with no transfer in between
	localparam int unsigned IDLE_LIMIT = 3_000_000;

	// receiver behaviour, changed after each span of random length
	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_HELD
	} ready_mode_t;

	logic                               clk;
	logic                               arst_n   = 1'b0;
	logic                               s_tvalid = 1'b0;
	wire logic                          s_tready;
	logic [S_DATA_W-1:0]                s_tdata  = '0;  // candidate
	wire logic                          m_tvalid;
	logic                               m_tready = 1'b0;
	wire logic [tdpt_pkg::OUT_TDATA_W-1:0] m_tdata;     // verdict, zero pad

	int mismatches;
	int outstanding;
	int verdicts_checked;
	int primes_seen;

	int sent        = 0;
	int burst_left  = 0;
	int idle_cycles = 0;

	trial_division_prime_test #(
		.DATA_WIDTH(DW)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	prime_verdict_checker #(
		.DATA_WIDTH(DW)
	) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.verdicts_checked(verdicts_checked),
		.primes_seen     (primes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one candidate transfer; a new burst may open with a gap of random length
	// valid stays high across a burst so each new candidate is offered at once
	task automatic send_candidate(input logic [31:0] value);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			else
				gap = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'(value);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	// directed candidates: field extremes, the below-two group, two and three,
	// even values, odd squares of primes, and a few primes of growing size
	logic [31:0] directed_candidates [$] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
		32'hFFFF_FFFF,   // minus one
		32'hFFFF_FFFE,   // minus two
		32'h8000_0000,   // most negative
		32'hAAAA_AAAA,   // negative, alternating bits
		32'h5555_5555,   // large odd, divisible by five
		32'd91, 32'd97, 32'd121, 32'd63001, 32'd65521, 32'd65535,
		32'd1000003,
		32'h7FFF_FFFE,   // largest even
		32'h7FFF_FFFD,   // large odd composite
		32'h7FFF_FFFF    // largest value, prime: the full divisor sweep
	};

	// stimulus
	initial begin
		logic [31:0] value;
		int unsigned pick;
		int unsigned factor;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_candidates[i])
			send_candidate(directed_candidates[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// full-width draw; positive odd ones are pushed negative so that
				// no random item can cost a sweep up to the root of 2^31
				value = $urandom;
				if (!value[31] && value[0])
					value[31] = 1'b1;
			end else if (pick < 40) begin
				// multiple of an odd factor below 1024, mostly large: stops early
				factor = 2 * $urandom_range(1, 511) + 1;
				value  = factor * $urandom_range(1, 32'h7FFF_FFFF / factor);
			end else if (pick < 50) begin
				// around the below-two boundary, negatives included
				value = $urandom_range(0, 40) - 8;
			end else if (pick < 60) begin
				value = $urandom_range(0, 1 << 20);
			end else begin
				value = $urandom_range(0, 65535);
			end
			send_candidate(value);
		end
		s_tvalid <= 1'b0;

		// checker outputs are registered
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d candidates sent (%0d directed), %0d verdicts checked, %0d prime",
			sent, directed_candidates.size(), verdicts_checked, primes_seen);
		$display("random part mixed wide draws, small-factor composites and small values");
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// result side: stall pattern of its own, including long ready stretches
	initial begin
		ready_mode_t mode;
		int unsigned span;
		@(posedge arst_n);
		forever begin
			mode = ready_mode_t'($urandom_range(0, 3));
			span = $urandom_range(4, 64);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					READY_ALWAYS: m_tready <= 1'b1;
					READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
					READY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
					default:      m_tready <= 1'b0;
				endcase
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
